### design/remc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// remc_pkg
// shared constants, register map and controller/datapath command types
// for the rate ema crossover monitor
// ----------------------------------------------------------------------------
package remc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int OUT_W       = 32;
    localparam int CONN_W      = 31;
    localparam int NUM_LANES   = 3;
    localparam int LANE_DATA   = 0;
    localparam int LANE_TTFB   = 1;
    localparam int LANE_CONN   = 2;

    localparam int PERIOD_W    = 6;
    localparam int WEIGHT_W    = 17;
    localparam int INTERVAL_W  = 4;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 2;

    localparam int NUM_EMA     = 4;
    localparam int EMA_IDX_W   = $clog2(NUM_EMA);
    localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = VALUE_WIDTH + WEIGHT_W + 1;

    localparam logic [WEIGHT_W-1:0]   Q16_ONE        = WEIGHT_W'(1 << FRAC_W);
    localparam logic [PERIOD_W-1:0]   PERIOD_RST     = PERIOD_W'(5);
    localparam logic [WEIGHT_W-1:0]   SHORT_K_RST    = WEIGHT_W'(21845);
    localparam logic [WEIGHT_W-1:0]   LONG_K_RST     = WEIGHT_W'(5041);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST   = INTERVAL_W'(5);

    // register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_PERIOD   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_K  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LONG_K   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 2'd3;

    // ema slots
    localparam logic [EMA_IDX_W-1:0] EMA_RATE_SHORT = 2'd0;
    localparam logic [EMA_IDX_W-1:0] EMA_TTFB_SHORT = 2'd1;
    localparam logic [EMA_IDX_W-1:0] EMA_RATE_LONG  = 2'd2;
    localparam logic [EMA_IDX_W-1:0] EMA_TTFB_LONG  = 2'd3;

    typedef struct packed {
        logic [PERIOD_W-1:0]   period_seconds;
        logic [WEIGHT_W-1:0]   short_weight_q16;
        logic [WEIGHT_W-1:0]   long_weight_q16;
        logic [INTERVAL_W-1:0] long_interval;
    } t_cfg;

    typedef struct packed {
        logic                 capture;
        logic                 div_load;
        logic                 div_step;
        logic                 rate_wr;
        logic                 mul_a;
        logic                 mul_b;
        logic                 sum;
        logic                 ema_wr;
        logic                 out_load;
        logic [EMA_IDX_W-1:0] ema_idx;
        logic                 long_upd;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

### design/remc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// remc_if
// valid/ready channels for tick snapshots in and rate/ema results out
// ----------------------------------------------------------------------------
interface remc_in_if import remc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] data_rate_sum;
    logic [VALUE_WIDTH-1:0] ttfb_sum;
    logic [VALUE_WIDTH-1:0] connection_count;

    modport source (
        output valid, data_rate_sum, ttfb_sum, connection_count,
        input  ready
    );
    modport sink (
        input  valid, data_rate_sum, ttfb_sum, connection_count,
        output ready
    );
endinterface

interface remc_out_if import remc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  data_rate;
    logic signed [OUT_W-1:0]  ttfb_rate;
    logic        [CONN_W-1:0] connection_rate;
    logic signed [OUT_W-1:0]  rate_ema_short;
    logic signed [OUT_W-1:0]  rate_ema_long;
    logic signed [OUT_W-1:0]  ttfb_ema_short;
    logic signed [OUT_W-1:0]  ttfb_ema_long;
    logic                     death_cross;

    modport source (
        output valid, data_rate, ttfb_rate, connection_rate, rate_ema_short,
               rate_ema_long, ttfb_ema_short, ttfb_ema_long, death_cross,
        input  ready
    );
    modport sink (
        input  valid, data_rate, ttfb_rate, connection_rate, rate_ema_short,
               rate_ema_long, ttfb_ema_short, ttfb_ema_long, death_cross,
        output ready
    );
endinterface
`default_nettype wire

### design/remc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// remc_div
// restoring divider, one quotient bit per step, one lane per counter
// ----------------------------------------------------------------------------
module remc_div import remc_pkg::*; (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_load,
    input  wire logic                                   i_step,
    input  wire logic [PERIOD_W-1:0]                    i_divisor,
    input  wire logic [NUM_LANES-1:0][VALUE_WIDTH-1:0]  i_dividend,
    output      logic [NUM_LANES-1:0][VALUE_WIDTH-1:0]  o_quotient
);

    logic [NUM_LANES-1:0][PERIOD_W-1:0]    r_rem;
    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] r_quo;
    logic [NUM_LANES-1:0][PERIOD_W-1:0]    n_rem;
    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] n_quo;
    logic [NUM_LANES-1:0][PERIOD_W:0]      w_trial;
    logic [NUM_LANES-1:0][PERIOD_W:0]      w_diff;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            w_trial[i] = {r_rem[i], r_quo[i][VALUE_WIDTH-1]};
            w_diff[i]  = w_trial[i] - {1'b0, i_divisor};
            n_rem[i]   = r_rem[i];
            n_quo[i]   = r_quo[i];
            if (i_load) begin
                n_rem[i] = '0;
                n_quo[i] = i_dividend[i];
            end else if (i_step) begin
                if (w_trial[i] >= {1'b0, i_divisor}) begin
                    n_rem[i] = w_diff[i][PERIOD_W-1:0];
                    n_quo[i] = {r_quo[i][VALUE_WIDTH-2:0], 1'b1};
                end else begin
                    n_rem[i] = w_trial[i][PERIOD_W-1:0];
                    n_quo[i] = {r_quo[i][VALUE_WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_quotient = r_quo;

endmodule
`default_nettype wire

### design/remc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// remc_datapath
// snapshot differences, rate division, shared multiplier for the emas,
// crossover flag and the output register
// ----------------------------------------------------------------------------
module remc_datapath import remc_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cfg                     i_cfg,
    input  wire t_cmd                     i_cmd,
    output      t_stat                    o_stat,
    input  wire logic [VALUE_WIDTH-1:0]   i_data_rate_sum,
    input  wire logic [VALUE_WIDTH-1:0]   i_ttfb_sum,
    input  wire logic [VALUE_WIDTH-1:0]   i_connection_count,
    input  wire logic                     i_out_ready,
    output      logic                     o_out_valid,
    output      logic signed [OUT_W-1:0]  o_data_rate,
    output      logic signed [OUT_W-1:0]  o_ttfb_rate,
    output      logic        [CONN_W-1:0] o_connection_rate,
    output      logic signed [OUT_W-1:0]  o_rate_ema_short,
    output      logic signed [OUT_W-1:0]  o_rate_ema_long,
    output      logic signed [OUT_W-1:0]  o_ttfb_ema_short,
    output      logic signed [OUT_W-1:0]  o_ttfb_ema_long,
    output      logic                     o_death_cross
);

    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] w_cur;
    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] r_prev;
    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] r_diff;
    logic [NUM_LANES-1:0]                  r_neg;
    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] w_mag;
    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] w_quo;
    logic [PERIOD_W-1:0]                   w_period;

    logic signed [VALUE_WIDTH-1:0] r_dr;
    logic signed [VALUE_WIDTH-1:0] r_tt;
    logic        [CONN_W-1:0]      r_cr;
    logic signed [VALUE_WIDTH-1:0] r_ema [NUM_EMA];
    logic                          r_was_above;

    logic        [WEIGHT_W-1:0]    w_k_raw;
    logic        [WEIGHT_W-1:0]    w_k;
    logic        [WEIGHT_W-1:0]    w_k_inv;
    logic signed [VALUE_WIDTH-1:0] w_x;
    logic signed [WEIGHT_W:0]      w_y;
    logic signed [PROD_W-1:0]      w_prod;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [PROD_W-1:0]      r_acc;
    logic signed [PROD_W-1:0]      w_bias;
    logic signed [PROD_W-1:0]      w_trunc;
    logic signed [VALUE_WIDTH-1:0] w_ema_new;
    logic                          w_ema_we;

    logic                          r_out_valid;
    logic signed [OUT_W-1:0]       r_out_dr;
    logic signed [OUT_W-1:0]       r_out_tt;
    logic        [CONN_W-1:0]      r_out_cr;
    logic signed [OUT_W-1:0]       r_out_rs;
    logic signed [OUT_W-1:0]       r_out_rl;
    logic signed [OUT_W-1:0]       r_out_ts;
    logic signed [OUT_W-1:0]       r_out_tl;
    logic                          r_out_cross;

    assign w_cur[LANE_DATA] = i_data_rate_sum;
    assign w_cur[LANE_TTFB] = i_ttfb_sum;
    assign w_cur[LANE_CONN] = i_connection_count;

    assign w_period = (i_cfg.period_seconds == '0) ? PERIOD_W'(1) : i_cfg.period_seconds;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            w_mag[i] = r_diff[i][VALUE_WIDTH-1] ? (~r_diff[i] + 1'b1) : r_diff[i];
        end
    end

    remc_div u_div (
        .i_clk      (i_clk),
        .i_load     (i_cmd.div_load),
        .i_step     (i_cmd.div_step),
        .i_divisor  (w_period),
        .i_dividend (w_mag),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_cmd.capture) begin
            r_prev <= w_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_diff[i] <= w_cur[i] - r_prev[i];
            end
            r_was_above <= r_ema[EMA_RATE_SHORT] > r_ema[EMA_RATE_LONG];
        end
        if (i_cmd.div_load) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_neg[i] <= r_diff[i][VALUE_WIDTH-1];
            end
        end
        if (i_cmd.rate_wr) begin
            r_dr <= r_neg[LANE_DATA] ? -$signed(w_quo[LANE_DATA]) : $signed(w_quo[LANE_DATA]);
            r_tt <= r_neg[LANE_TTFB] ? -$signed(w_quo[LANE_TTFB]) : $signed(w_quo[LANE_TTFB]);
            r_cr <= r_neg[LANE_CONN] ? '0 : w_quo[LANE_CONN][CONN_W-1:0];
        end
    end

    // ema = (cur*k + old*(1-k)) / 2^16, truncated toward zero
    assign w_k_raw  = i_cmd.ema_idx[1] ? i_cfg.long_weight_q16 : i_cfg.short_weight_q16;
    assign w_k      = (w_k_raw > Q16_ONE) ? Q16_ONE : w_k_raw;
    assign w_k_inv  = Q16_ONE - w_k;
    assign w_x      = i_cmd.mul_a ? (i_cmd.ema_idx[0] ? r_tt : r_dr) : r_ema[i_cmd.ema_idx];
    assign w_y      = $signed({1'b0, (i_cmd.mul_a ? w_k : w_k_inv)});
    assign w_prod   = PROD_W'(w_x * w_y);
    assign w_bias   = r_acc[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : '0;
    assign w_trunc  = r_acc + w_bias;
    assign w_ema_new = w_trunc[FRAC_W +: VALUE_WIDTH];
    assign w_ema_we  = i_cmd.ema_wr && (!i_cmd.ema_idx[1] || i_cmd.long_upd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_a || i_cmd.mul_b) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mul_b) begin
            r_acc <= r_prod;
        end else if (i_cmd.sum) begin
            r_acc <= r_acc + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_EMA; i++) begin
                r_ema[i] <= '0;
            end
        end else if (w_ema_we) begin
            r_ema[i_cmd.ema_idx] <= w_ema_new;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_dr    <= r_dr;
            r_out_tt    <= r_tt;
            r_out_cr    <= r_cr;
            r_out_rs    <= r_ema[EMA_RATE_SHORT];
            r_out_rl    <= r_ema[EMA_RATE_LONG];
            r_out_ts    <= r_ema[EMA_TTFB_SHORT];
            r_out_tl    <= r_ema[EMA_TTFB_LONG];
            r_out_cross <= r_was_above && (r_ema[EMA_RATE_LONG] > r_ema[EMA_RATE_SHORT])
                           && (r_cr != '0);
        end
    end

    assign o_stat.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_data_rate        = r_out_dr;
    assign o_ttfb_rate        = r_out_tt;
    assign o_connection_rate  = r_out_cr;
    assign o_rate_ema_short   = r_out_rs;
    assign o_rate_ema_long    = r_out_rl;
    assign o_ttfb_ema_short   = r_out_ts;
    assign o_ttfb_ema_long    = r_out_tl;
    assign o_death_cross      = r_out_cross;

endmodule
`default_nettype wire

### design/remc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// remc_ctrl
// sequencer: capture, divide, four ema passes, hand result to output
// ----------------------------------------------------------------------------
module remc_ctrl import remc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_ready,
    input  wire logic [INTERVAL_W-1:0] i_long_interval,
    input  wire t_stat                 i_stat,
    output      t_cmd                  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DIV_LOAD = 9'b000000010,
        S_DIV_RUN  = 9'b000000100,
        S_RATE     = 9'b000001000,
        S_MUL_A    = 9'b000010000,
        S_MUL_B    = 9'b000100000,
        S_SUM      = 9'b001000000,
        S_EMA_WR   = 9'b010000000,
        S_OUT      = 9'b100000000
    } t_state;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(VALUE_WIDTH - 1);
    localparam logic [EMA_IDX_W-1:0] EMA_LAST = EMA_IDX_W'(NUM_EMA - 1);

    t_state                r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [EMA_IDX_W-1:0]  r_idx, n_idx;
    logic [INTERVAL_W-1:0] r_tick, n_tick;
    logic                  r_long_upd, n_long_upd;
    logic [INTERVAL_W-1:0] w_tick_inc;
    logic [INTERVAL_W-1:0] w_interval;
    logic                  w_upd;

    assign w_tick_inc = r_tick + 1'b1;
    assign w_interval = (i_long_interval == '0) ? INTERVAL_W'(1) : i_long_interval;
    assign w_upd      = w_tick_inc >= w_interval;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_tick       = r_tick;
        n_long_upd   = r_long_upd;
        o_cmd          = '0;
        o_cmd.ema_idx  = r_idx;
        o_cmd.long_upd = r_long_upd;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_long_upd    = w_upd;
                    n_tick        = w_upd ? '0 : w_tick_inc;
                    n_state       = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_RATE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RATE: begin
                o_cmd.rate_wr = 1'b1;
                n_idx         = '0;
                n_state       = S_MUL_A;
            end
            S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_EMA_WR;
            end
            S_EMA_WR: begin
                o_cmd.ema_wr = 1'b1;
                if (r_idx == EMA_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_MUL_A;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_idx      <= '0;
            r_tick     <= '0;
            r_long_upd <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_idx      <= n_idx;
            r_tick     <= n_tick;
            r_long_upd <= n_long_upd;
        end
    end

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded while output register occupied");

    a_div_full_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_RUN && n_state == S_RATE) |-> (r_cnt == DIV_LAST))
        else $error("divider left before all quotient bits");

    a_long_upd_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && $past(r_state != S_IDLE)) |-> $stable(r_long_upd))
        else $error("long update flag changed mid item");

    a_tick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick != {INTERVAL_W{1'b1}})
        else $error("tick counter reached all ones");

    a_ready_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(o_cmd.div_step || o_cmd.ema_wr || o_cmd.out_load))
        else $error("datapath command while idle");

endmodule
`default_nettype wire

### design/rate_ema_crossover_monitor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rate_ema_crossover_monitor
// per-tick rates from counter snapshots, short/long emas and death cross flag
//
// i_in carries one beat per tick period: snapshots of the data-rate sum, the
// first-byte time sum and the connection count. o_out returns one beat per
// input beat with the three per-second rates, the four emas and the flag.
// The apb port sets period, ema weights and long interval; write only idle.
// From input beat to output valid the sequencer runs a divider load, 32
// steps of the three-lane restoring divider, a rate write, for each of
// the four emas a multiply, multiply, sum and ema write on the shared
// multiplier, and an output load; a new beat waits for the output load.
// The output register frees the sequencer: the next beat is accepted while
// a finished result waits; if the receiver still stalls at the end of that
// next tick, the sequencer holds until the output register is taken.
// Reset (synchronous, active low) restores the register defaults and clears
// the held snapshots, emas and tick counter; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rate_ema_crossover_monitor import remc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    remc_in_if.sink                    i_in,
    remc_out_if.source                 o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    t_cfg                 r_cfg;
    t_cmd                 w_cmd;
    t_stat                w_stat;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_seconds   <= PERIOD_RST;
            r_cfg.short_weight_q16 <= SHORT_K_RST;
            r_cfg.long_weight_q16  <= LONG_K_RST;
            r_cfg.long_interval    <= INTERVAL_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_PERIOD:   r_cfg.period_seconds   <= pwdata[PERIOD_W-1:0];
                REG_SHORT_K:  r_cfg.short_weight_q16 <= pwdata[WEIGHT_W-1:0];
                REG_LONG_K:   r_cfg.long_weight_q16  <= pwdata[WEIGHT_W-1:0];
                REG_INTERVAL: r_cfg.long_interval    <= pwdata[INTERVAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PERIOD:   prdata = APB_DATA_W'(r_cfg.period_seconds);
            REG_SHORT_K:  prdata = APB_DATA_W'(r_cfg.short_weight_q16);
            REG_LONG_K:   prdata = APB_DATA_W'(r_cfg.long_weight_q16);
            REG_INTERVAL: prdata = APB_DATA_W'(r_cfg.long_interval);
            default:      prdata = '0;
        endcase
    end

    remc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in.valid),
        .o_in_ready      (i_in.ready),
        .i_long_interval (r_cfg.long_interval),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    remc_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_data_rate_sum    (i_in.data_rate_sum),
        .i_ttfb_sum         (i_in.ttfb_sum),
        .i_connection_count (i_in.connection_count),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_data_rate        (o_out.data_rate),
        .o_ttfb_rate        (o_out.ttfb_rate),
        .o_connection_rate  (o_out.connection_rate),
        .o_rate_ema_short   (o_out.rate_ema_short),
        .o_rate_ema_long    (o_out.rate_ema_long),
        .o_ttfb_ema_short   (o_out.ttfb_ema_short),
        .o_ttfb_ema_long    (o_out.ttfb_ema_long),
        .o_death_cross      (o_out.death_cross)
    );

endmodule
`default_nettype wire
